// ===== hw/rtl/serial_pair_command_decoder_top_defines.svh =====
// Assertion macros for the serial pair command decoder.
// Both expect clk and rst in scope at the place of use.
`ifndef SERIAL_PAIR_COMMAND_DECODER_TOP_DEFINES_SVH
`define SERIAL_PAIR_COMMAND_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPCD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define SPCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPCD_ASSERT(label, prop)
`define SPCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/spcd_pkg.sv =====
`default_nettype none
package spcd_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam int IN_BYTES  = 1;
  localparam int OUT_BITS  = 52;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  localparam logic [10:0] SERVO_BASE  = 11'd500;
  localparam logic [10:0] SERVO_RESET = 11'd1000;

  // instruction codes
  localparam logic [3:0] CODE_CHARGE_ON  = 4'd0;
  localparam logic [3:0] CODE_CHARGE_OFF = 4'd1;
  localparam logic [3:0] CODE_FIRE_ON    = 4'd2;
  localparam logic [3:0] CODE_FIRE_OFF   = 4'd3;
  localparam logic [3:0] CODE_LEFT_REV   = 4'd4;
  localparam logic [3:0] CODE_LEFT_FWD   = 4'd5;
  localparam logic [3:0] CODE_RIGHT_REV  = 4'd6;
  localparam logic [3:0] CODE_RIGHT_FWD  = 4'd7;
  localparam logic [3:0] CODE_TURN_REV   = 4'd8;
  localparam logic [3:0] CODE_TURN_FWD   = 4'd9;
  localparam logic [3:0] CODE_COIL_REV   = 4'd10;
  localparam logic [3:0] CODE_COIL_FWD   = 4'd11;
  localparam logic [3:0] CODE_RELAY_CHK  = 4'd13;
  localparam logic [3:0] CODE_PROJ_CHK   = 4'd14;
  localparam logic [3:0] CODE_SERVO      = 4'd15;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_APPLIED = 3'd1,
    EV_RELAY   = 3'd2,
    EV_PROJ    = 3'd3,
    EV_IGNORED = 3'd4
  } event_t;

  // one classified byte, front to back
  typedef struct packed {
    logic       complete;
    logic [3:0] code;
    logic [9:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // result beat, first field in the highest bits
  typedef struct packed {
    event_t      event_res;
    logic [10:0] servo_pulse_us;
    logic        fire_active;
    logic        charge_on;
    logic        coil_dir;
    logic [7:0]  coil_speed;
    logic        turntable_dir;
    logic [7:0]  turntable_speed;
    logic        right_forward;
    logic [7:0]  right_speed;
    logic        left_forward;
    logic [7:0]  left_speed;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spcd_front.sv =====
`default_nettype none
module spcd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_byte,
  input  wire spcd_pkg::q_status_t q_stat,
  output logic                     in_ready,
  output logic                     push,
  output spcd_pkg::cmd_t           push_cmd
);

  logic       pair_pending;
  logic       pending_low;
  logic [6:0] low_bits;
  logic [6:0] high_bits;

  logic       is_low;
  logic [6:0] low_bits_next;
  logic [6:0] high_bits_next;
  logic       complete;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign is_low         = in_byte[7];
  assign low_bits_next  = is_low ? in_byte[6:0] : low_bits;
  assign high_bits_next = is_low ? high_bits : in_byte[6:0];
  // opposite mark to the waiting byte closes the pair; same mark restarts it
  assign complete       = pair_pending && (pending_low != is_low);

  always_comb begin
    push_cmd.complete = complete;
    push_cmd.code     = high_bits_next[6:3];
    push_cmd.data     = {high_bits_next[2:0], low_bits_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_pending <= 1'b0;
      pending_low  <= 1'b0;
      low_bits     <= '0;
      high_bits    <= '0;
    end else if (push) begin
      low_bits     <= low_bits_next;
      high_bits    <= high_bits_next;
      pair_pending <= !complete;
      if (!complete) begin
        pending_low <= is_low;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spcd_fifo.sv =====
`default_nettype none
module spcd_fifo #(
  parameter int Depth = spcd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire spcd_pkg::cmd_t  din,
  input  wire logic            pop,
  output spcd_pkg::cmd_t       dout,
  output spcd_pkg::q_status_t  status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  spcd_pkg::cmd_t  slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign dout         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spcd_back.sv =====
`default_nettype none
module spcd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spcd_pkg::q_status_t q_stat,
  input  wire spcd_pkg::cmd_t      cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spcd_pkg::result_t        out_res
);

  spcd_pkg::result_t drive;       // live drive registers, event field unused
  spcd_pkg::result_t drive_next;

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_comb begin
    drive_next           = drive;
    drive_next.event_res = spcd_pkg::EV_NONE;
    if (cmd.complete) begin
      drive_next.event_res = spcd_pkg::EV_APPLIED;
      unique case (cmd.code)
        spcd_pkg::CODE_CHARGE_ON:  drive_next.charge_on = 1'b1;
        spcd_pkg::CODE_CHARGE_OFF: drive_next.charge_on = 1'b0;
        spcd_pkg::CODE_FIRE_ON:    drive_next.fire_active = 1'b1;
        spcd_pkg::CODE_FIRE_OFF:   drive_next.fire_active = 1'b0;
        spcd_pkg::CODE_LEFT_REV, spcd_pkg::CODE_LEFT_FWD: begin
          drive_next.left_speed   = cmd.data[7:0];
          drive_next.left_forward = cmd.code[0];
        end
        spcd_pkg::CODE_RIGHT_REV, spcd_pkg::CODE_RIGHT_FWD: begin
          drive_next.right_speed   = cmd.data[7:0];
          drive_next.right_forward = cmd.code[0];
        end
        spcd_pkg::CODE_TURN_REV, spcd_pkg::CODE_TURN_FWD: begin
          drive_next.turntable_speed = cmd.data[7:0];
          drive_next.turntable_dir   = cmd.code[0];
        end
        spcd_pkg::CODE_COIL_REV, spcd_pkg::CODE_COIL_FWD: begin
          drive_next.coil_speed = cmd.data[7:0];
          drive_next.coil_dir   = cmd.code[0];
        end
        spcd_pkg::CODE_RELAY_CHK: drive_next.event_res = spcd_pkg::EV_RELAY;
        spcd_pkg::CODE_PROJ_CHK:  drive_next.event_res = spcd_pkg::EV_PROJ;
        spcd_pkg::CODE_SERVO:
          drive_next.servo_pulse_us = {1'b0, cmd.data} + spcd_pkg::SERVO_BASE;
        default:                  drive_next.event_res = spcd_pkg::EV_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive     <= '{event_res:      spcd_pkg::EV_NONE,
                     servo_pulse_us: spcd_pkg::SERVO_RESET,
                     default:        '0};
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        drive     <= drive_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= drive_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_pair_command_decoder_top.sv =====
// Serial pair command decoder: pairs marked serial bytes into 14-bit commands.
// Path: an accepted byte is written to a queue slot, then executed into the output
//   register once the output is free.
// Throughput: one byte per cycle while the queue is not full; the queue lets intake run on while m_tready is low.
// Reset (rst, synchronous, active high): no pending half, drives zero, servo 1000 us.
`default_nettype none
`include "serial_pair_command_decoder_top_defines.svh"
module serial_pair_command_decoder_top #(
  parameter int FifoDepth = spcd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // slave side
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [8*spcd_pkg::IN_BYTES-1:0]  s_tdata,  // [7:0] rx_byte
  // master side
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [7:0] left_speed, [8] left_forward, [16:9] right_speed, [17] right_forward,
  // [25:18] turntable_speed, [26] turntable_dir, [34:27] coil_speed,
  // [35] coil_dir, [36] charge_on, [37] fire_active, [48:38] servo_pulse_us,
  // [51:49] event_res, [55:52] zero
  output logic [8*spcd_pkg::OUT_BYTES-1:0]      m_tdata
);

  localparam int PadW = 8 * spcd_pkg::OUT_BYTES - spcd_pkg::OUT_BITS;

  spcd_pkg::q_status_t q_stat;
  spcd_pkg::cmd_t      push_cmd;
  spcd_pkg::cmd_t      head_cmd;
  spcd_pkg::result_t   res;
  logic                push;
  logic                pop;

  // front: pairs bytes, every byte becomes one queue entry
  spcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata[7:0]),
    .q_stat   (q_stat),
    .in_ready (s_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // short queue between classify and execute
  spcd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_cmd),
    .pop    (pop),
    .dout   (head_cmd),
    .status (q_stat)
  );

  // back: executes commands, registers the drive snapshot
  spcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {{PadW{1'b0}}, res};

  `SPCD_ASSERT(a_servo_range,
    !m_tvalid || (res.servo_pulse_us >= 11'd500 && res.servo_pulse_us <= 11'd1523))
  `SPCD_ASSERT(a_stall_only_full, s_tready || (q_stat.full && !q_stat.empty))
  `SPCD_ASSERT_NEXT(a_push_fills, push && q_stat.empty, !q_stat.empty || m_tvalid)

endmodule
`default_nettype wire
